[design/cba_pkg.sv]
// Shared constants, types and codes of the contiguous block allocator.
package cba_pkg;

  localparam int NUM_BLOCKS  = 256;
  localparam int BLOCK_BYTES = 128;

  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 15;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = $clog2(NUM_BLOCKS);
  localparam int RUN_W    = $clog2(NUM_BLOCKS + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED   = 2'd0,
    ST_NO_SPACE    = 2'd1,
    ST_RELEASED    = 2'd2,
    ST_BAD_ADDRESS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_RCHK,
    S_CLEAR,
    S_RESP
  } state_t;

  // One block: used flag, run length held at the last block of an allocation
  typedef struct packed {
    logic             used;
    logic [RUN_W-1:0] run;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } store_wr_t;

endpackage

[design/cba_req_if.sv]
// Request channel: kind, size and address with valid/ready.
interface cba_req_if
  import cba_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SIZE_W-1:0] size;
  logic [ADDR_W-1:0] address;

  modport source (output valid, kind, size, address, input ready);
  modport sink   (input valid, kind, size, address, output ready);
endinterface

[design/cba_rsp_if.sv]
// Response channel: status and result address with valid/ready.
interface cba_rsp_if
  import cba_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   result_address;

  modport source (output valid, status, result_address, input ready);
  modport sink   (input valid, status, result_address, output ready);
endinterface

[design/cba_store.sv]
// Block state memory: one entry per block, valid bits give the reset value.
module cba_store
  import cba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_addr,
  input  store_wr_t        wr,
  output entry_t           rd_data
);

  entry_t                mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld;
  entry_t                q;
  logic                  q_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      q_vld <= vld[rd_addr];
    end
  end

  // never-written entry reads as free with no run
  assign rd_data = q_vld ? q : '0;

endmodule

[design/contiguous_block_allocator.sv]
// Top level: first-fit allocator over a pool of fixed-size blocks.
//
//   channel | dir | payload                  | accepted when
//   req     | in  | kind, size, address      | req.valid && req.ready
//   rsp     | out | status, result_address   | rsp.valid && rsp.ready
//
// Allocate: the state memory is scanned one entry a cycle up to the run's last
// block, then the run is written back one entry a cycle; a scan that finds no run
// reads every entry. Release: the addressed entry is checked, then the run is
// cleared. Zero size skips the scan, a bad offset the check, a failed check the clear.
// Reset clears the memory's valid bits at once; no clearing pass.
// One request at a time; ready is high in idle, and a finished response waits
// in the output register, holding off completion of the next one until taken.
module contiguous_block_allocator
  import cba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cba_req_if.sink     req,
  cba_rsp_if.source   rsp
);

  state_t            state, state_next;
  logic [IDX_W-1:0]  cur, cur_next;
  logic [RUN_W-1:0]  run, run_next;
  logic [SIZE_W-1:0] need, need_next;
  logic [RUN_W-1:0]  cnt, cnt_next;
  logic [IDX_W-1:0]  wr_idx, wr_idx_next;
  status_t           res_status, res_status_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;

  logic [IDX_W-1:0]  rd_addr;
  store_wr_t         wr;
  entry_t            rd_data;

  logic              accept;
  logic              load;
  logic [ADDR_W-1:0] slot;
  logic              rel_ok;
  logic [IDX_W-1:0]  rel_idx;
  logic [RUN_W-1:0]  run_inc;
  logic              found;
  logic [RUN_W-1:0]  span;

  cba_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (rd_data)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign load      = (state == S_RESP) && (!rsp.valid || rsp.ready);

  assign slot    = ADDR_W'(req.address / BLOCK_BYTES);
  assign rel_ok  = ((req.address % BLOCK_BYTES) == 0) && (32'(slot) < 32'(NUM_BLOCKS));
  assign rel_idx = IDX_W'(32'(NUM_BLOCKS - 1) - 32'(slot));

  assign run_inc = rd_data.used ? '0 : run + RUN_W'(1);
  assign found   = (run_inc != '0) && (SIZE_W'(run_inc) >= need);

  // a run cannot reach past block 0
  assign span = (rd_data.run > (RUN_W'(wr_idx) + RUN_W'(1)))
              ? (RUN_W'(wr_idx) + RUN_W'(1)) : rd_data.run;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    run_next        = run;
    need_next       = need;
    cnt_next        = cnt;
    wr_idx_next     = wr_idx;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    rd_addr         = '0;
    wr              = '0;

    case (state)
      S_IDLE: begin
        rd_addr = req.kind ? rel_idx : '0;
        if (accept) begin
          cur_next      = '0;
          run_next      = '0;
          res_addr_next = '0;
          need_next     = SIZE_W'((32'(req.size) + 32'(BLOCK_BYTES - 1)) / BLOCK_BYTES);
          wr_idx_next   = rel_idx;
          if (!req.kind) begin
            if (req.size == '0) begin
              res_status_next = ST_NO_SPACE;
              state_next      = S_RESP;
            end else begin
              state_next = S_SCAN;
            end
          end else if (rel_ok) begin
            state_next = S_RCHK;
          end else begin
            res_status_next = ST_BAD_ADDRESS;
            state_next      = S_RESP;
          end
        end
      end

      S_SCAN: begin
        rd_addr = cur + IDX_W'(1);
        if (found) begin
          wr.en           = 1'b1;
          wr.addr         = cur;
          wr.data.used    = 1'b1;
          wr.data.run     = run_inc;
          res_status_next = ST_ALLOCATED;
          res_addr_next   = ADDR_W'((32'(NUM_BLOCKS - 1) - 32'(cur)) * 32'(BLOCK_BYTES));
          wr_idx_next     = cur - IDX_W'(1);
          cnt_next        = run_inc - RUN_W'(1);
          state_next      = (run_inc == RUN_W'(1)) ? S_RESP : S_MARK;
        end else if (32'(cur) == 32'(NUM_BLOCKS - 1)) begin
          res_status_next = ST_NO_SPACE;
          state_next      = S_RESP;
        end else begin
          cur_next = cur + IDX_W'(1);
          run_next = run_inc;
        end
      end

      // inner blocks of a new run: used, no run length
      S_MARK: begin
        wr.en        = 1'b1;
        wr.addr      = wr_idx;
        wr.data.used = 1'b1;
        wr.data.run  = '0;
        wr_idx_next  = wr_idx - IDX_W'(1);
        cnt_next     = cnt - RUN_W'(1);
        if (cnt == RUN_W'(1)) begin
          state_next = S_RESP;
        end
      end

      S_RCHK: begin
        if (!rd_data.used || rd_data.run == '0) begin
          res_status_next = ST_BAD_ADDRESS;
          state_next      = S_RESP;
        end else begin
          cnt_next   = span;
          state_next = S_CLEAR;
        end
      end

      S_CLEAR: begin
        wr.en       = 1'b1;
        wr.addr     = wr_idx;
        wr.data     = '0;
        wr_idx_next = wr_idx - IDX_W'(1);
        cnt_next    = cnt - RUN_W'(1);
        if (cnt == RUN_W'(1)) begin
          res_status_next = ST_RELEASED;
          state_next      = S_RESP;
        end
      end

      S_RESP: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    run        <= run_next;
    need       <= need_next;
    cnt        <= cnt_next;
    wr_idx     <= wr_idx_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status         <= res_status;
      rsp.result_address <= res_addr;
    end
  end

endmodule

[tb/cba_checker.sv]
// Checker for the block allocator: pool prediction and response comparison.
`timescale 1ns / 1ps

module cba_checker
  import cba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  cba_req_if   req,
  cba_rsp_if   rsp,
  output int   errors,
  output int   pending
);

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] offset;
  } grant_t;

  grant_t           expected_grants[$];
  bit               block_taken[NUM_BLOCKS];
  bit [RUN_W-1:0]   run_at[NUM_BLOCKS];
  int               mismatches  = 0;
  int               outstanding = 0;

  assign errors  = mismatches;
  assign pending = outstanding;

  // First fit in index order; the run length is kept at the run's last block
  function automatic grant_t allocate_run(int unsigned nbytes);
    grant_t      g;
    int unsigned run;
    g.status = ST_NO_SPACE;
    g.offset = '0;
    run = 0;
    if (nbytes == 0) return g;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (!block_taken[i]) run++;
      else run = 0;
      if (run != 0 && run * BLOCK_BYTES >= nbytes) begin
        run_at[i] = RUN_W'(run);
        for (int k = 0; k < run; k++) block_taken[i-k] = 1'b1;
        g.status = ST_ALLOCATED;
        g.offset = ADDR_W'((NUM_BLOCKS - 1 - i) * BLOCK_BYTES);
        return g;
      end
    end
    return g;
  endfunction

  function automatic grant_t free_run(logic [ADDR_W-1:0] offset);
    grant_t      g;
    int unsigned ofs;
    int unsigned slot;
    int unsigned last;
    int unsigned len;
    g.status = ST_BAD_ADDRESS;
    g.offset = '0;
    ofs = 32'(offset);
    if (ofs % BLOCK_BYTES != 0) return g;
    slot = ofs / BLOCK_BYTES;
    if (slot >= NUM_BLOCKS) return g;
    last = NUM_BLOCKS - 1 - slot;
    len  = 32'(run_at[last]);
    // free blocks and inner blocks of a run carry no length
    if (!block_taken[last] || len == 0) return g;
    for (int k = 0; k < len && k <= last; k++) begin
      block_taken[last-k] = 1'b0;
      run_at[last-k]      = '0;
    end
    g.status = ST_RELEASED;
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        block_taken[i] = 1'b0;
        run_at[i]      = '0;
      end
      expected_grants.delete();
    end else begin
      // response first: a request taken on this edge cannot be answered on it
      if (rsp.valid && rsp.ready) begin
        if (expected_grants.size() == 0) begin
          $error("unexpected response: status %0d result_address %0d",
                 rsp.status, rsp.result_address);
          mismatches++;
        end else begin
          want = expected_grants.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.result_address !== want.offset) begin
            $error("result_address: expected %0d, got %0d",
                   want.offset, rsp.result_address);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.kind) expected_grants.push_back(free_run(req.address));
        else expected_grants.push_back(allocate_run(32'(req.size)));
      end
    end
    outstanding = expected_grants.size();
  end

endmodule

[tb/contiguous_block_allocator_tb.sv]
// Top of the block allocator testbench: clock, reset, request stimulus, verdict.
`timescale 1ns / 1ps

module contiguous_block_allocator_tb;
  import cba_pkg::*;

  localparam int RANDOM_ITEMS = 750;
  localparam int CALM_ITEMS   = 100;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   idle_cycles   = 0;
  bit   calm          = 1'b0;
  int   req_gap_pct   = 0;
  int   rsp_stall_pct = 0;

  logic [ADDR_W-1:0] live_offsets[$];

  cba_req_if req_ch ();
  cba_rsp_if rsp_ch ();

  always #4 clk = ~clk;

  contiguous_block_allocator DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  cba_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .pending (pending)
  );

  // granted offsets feed the well-formed releases
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_ALLOCATED)
      live_offsets.push_back(rsp_ch.result_address);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("contiguous_block_allocator_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // response back-pressure in bursts
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(99) < rsp_stall_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_request(logic kind, logic [SIZE_W-1:0] nbytes,
                              logic [ADDR_W-1:0] offset);
    @(negedge clk);
    req_ch.valid   <= 1'b1;
    req_ch.kind    <= kind;
    req_ch.size    <= nbytes;
    req_ch.address <= offset;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    if (!calm && $urandom_range(99) < req_gap_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8) - 1) @(negedge clk);
    end
  endtask

  // the unused field carries random bits
  task automatic grab(int unsigned nbytes);
    push_request(1'b0, SIZE_W'(nbytes), ADDR_W'($urandom));
  endtask

  task automatic give_back(int unsigned offset);
    push_request(1'b1, SIZE_W'($urandom), ADDR_W'(offset));
  endtask

  function automatic int pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 20;
      default: return 50;
    endcase
  endfunction

  initial begin
    int                roll;
    int                pick;
    int                idx;
    logic [ADDR_W-1:0] offset;
    req_ch.valid   = 1'b0;
    req_ch.kind    = 1'b0;
    req_ch.size    = '0;
    req_ch.address = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: size extremes, whole pool, inner and unaligned releases
    grab(0);
    grab(65535);
    grab(NUM_BLOCKS * BLOCK_BYTES + 1);
    grab(NUM_BLOCKS * BLOCK_BYTES);
    grab(1);
    give_back(0);
    give_back(0);
    grab(1);
    grab(3 * BLOCK_BYTES);
    give_back((NUM_BLOCKS - 3) * BLOCK_BYTES);
    give_back((NUM_BLOCKS - 2) * BLOCK_BYTES);
    give_back(2 ** ADDR_W - 1);
    give_back((NUM_BLOCKS - 4) * BLOCK_BYTES + 1);
    give_back((NUM_BLOCKS - 4) * BLOCK_BYTES);
    grab(BLOCK_BYTES);
    grab(BLOCK_BYTES + 1);
    push_request(1'b1, '1, ADDR_W'((NUM_BLOCKS - 1) * BLOCK_BYTES));
    push_request(1'b0, SIZE_W'(2 * BLOCK_BYTES), '1);
    give_back((NUM_BLOCKS - 2) * BLOCK_BYTES);
    give_back((NUM_BLOCKS - 4) * BLOCK_BYTES);
    give_back((NUM_BLOCKS - 6) * BLOCK_BYTES);
    grab((NUM_BLOCKS - 1) * BLOCK_BYTES);
    grab(BLOCK_BYTES);
    give_back(0);
    give_back(BLOCK_BYTES);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    live_offsets.delete();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        req_gap_pct   = pick_pct();
        rsp_stall_pct = pick_pct();
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      roll = $urandom_range(99);
      if (roll < (live_offsets.size() > 24 ? 65 : 35)) begin
        pick = $urandom_range(99);
        if (pick < 75 && live_offsets.size() != 0) begin
          idx    = $urandom_range(live_offsets.size() - 1);
          offset = live_offsets[idx];
          live_offsets.delete(idx);
          give_back(32'(offset));
        end else if (pick < 90) begin
          give_back($urandom_range(NUM_BLOCKS - 1) * BLOCK_BYTES);
        end else begin
          give_back($urandom_range(2 ** ADDR_W - 1));
        end
      end else begin
        pick = $urandom_range(99);
        if (pick < 5) grab(0);
        else if (pick < 10) grab($urandom_range(2 ** SIZE_W - 1));
        else if (pick < 15) grab($urandom_range(1, NUM_BLOCKS * BLOCK_BYTES));
        else grab($urandom_range(1, 8 * BLOCK_BYTES));
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("contiguous_block_allocator_tb: done, clean");
    end else begin
      $display("contiguous_block_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
design/cba_pkg.sv
design/cba_req_if.sv
design/cba_rsp_if.sv
design/cba_store.sv
design/contiguous_block_allocator.sv
tb/cba_checker.sv
tb/contiguous_block_allocator_tb.sv
